// ===== hw/rtl/mbs_pkg.sv =====
// Shared types and constants for the Modbus RTU slave frame handler.
package mbs_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } rx_word_t;

  typedef struct packed {
    logic [31:0] tx_bytes;
    logic [2:0]  tx_count;
    logic        tx_last;
    logic        reboot_request;
  } tx_word_t;

  typedef struct packed {
    logic       clr;
    logic       start;
    logic [7:0] din;
  } crc_cmd_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       reboot;
  } pk_push_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RXWAIT,
    ST_CHK1,
    ST_CHK2,
    ST_WR_RD0,
    ST_WR_RD1,
    ST_WR_WR,
    ST_TX_BYTE,
    ST_TX_CRC,
    ST_TX_LO,
    ST_TX_HI
  } state_t;

  typedef enum logic [1:0] {
    RK_EXC,
    RK_READ,
    RK_READ_ZERO,
    RK_WRITE
  } resp_kind_t;

  localparam logic [0:0]  CFG_SLAVE_ADDRESS = 1'b0;
  localparam logic [0:0]  CFG_STORE_BASE    = 1'b1;

  localparam logic [7:0]  SLAVE_ADDRESS_RESET = 8'h01;
  localparam logic [15:0] STORE_BASE_RESET    = 16'h2600;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0]  FN_READ_HOLDING  = 8'h03;
  localparam logic [7:0]  FN_WRITE_MULTI   = 8'h10;
  localparam logic [7:0]  EXC_FLAG         = 8'h80;
  localparam logic [15:0] REBOOT_REG       = 16'hFF00;
  localparam logic [15:0] WRITE_REGS_LIMIT = 16'd123;

  localparam logic [7:0]  EXC_ILLEGAL_FUNCTION = 8'h01;
  localparam logic [7:0]  EXC_ILLEGAL_ADDRESS  = 8'h02;
  localparam logic [7:0]  EXC_ILLEGAL_VALUE    = 8'h03;

  localparam int HDR_BYTES = 7;

endpackage

// ===== hw/rtl/mbs_crc.sv =====
// Bit-serial CRC-16/Modbus unit, one bit per cycle.
module mbs_crc
  import mbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  crc_cmd_t    cmd,
  output logic [15:0] crc,
  output logic        busy
);

  logic [3:0] bits_left;

  assign busy = (bits_left != 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc       <= CRC_INIT;
      bits_left <= 4'd0;
    end else if (cmd.clr) begin
      crc       <= CRC_INIT;
      bits_left <= 4'd0;
    end else if (cmd.start) begin
      crc       <= crc ^ {8'h00, cmd.din};
      bits_left <= 4'd8;
    end else if (busy) begin
      crc       <= crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      bits_left <= bits_left - 4'd1;
    end
  end

endmodule

// ===== hw/rtl/mbs_store.sv =====
// Holding-register store: word memory with a zeroing sweep after reset.
module mbs_store #(
  parameter int STORE_WORDS = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [15:0]          wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [15:0]          rdata,
  output logic                 busy
);

  localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

  logic [15:0]   mem [STORE_WORDS];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(STORE_WORDS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 16'h0000;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/mbs_txpack.sv =====
// Packs response bytes into four-byte words with an output register.
module mbs_txpack
  import mbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  pk_push_t push,
  output logic     ready,
  output logic     tx_valid,
  input  logic     tx_stall,
  output tx_word_t tx_word
);

  logic [31:0] acc_data;
  logic [2:0]  acc_cnt;
  logic        acc_last;
  logic        acc_reboot;
  logic        flush;
  logic        out_free;

  assign flush    = (acc_cnt == 3'd4) || acc_last;
  assign out_free = !tx_valid || !tx_stall;
  assign ready    = !flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid   <= 1'b0;
      acc_data   <= '0;
      acc_cnt    <= 3'd0;
      acc_last   <= 1'b0;
      acc_reboot <= 1'b0;
    end else if (flush && out_free) begin
      tx_valid               <= 1'b1;
      tx_word.tx_bytes       <= acc_data;
      tx_word.tx_count       <= acc_cnt;
      tx_word.tx_last        <= acc_last;
      tx_word.reboot_request <= acc_reboot;
      acc_data               <= '0;
      acc_cnt                <= 3'd0;
      acc_last               <= 1'b0;
      acc_reboot             <= 1'b0;
    end else begin
      if (tx_valid && !tx_stall) begin
        tx_valid <= 1'b0;
      end
      if (push.valid) begin
        acc_data[{acc_cnt[1:0], 3'b000} +: 8] <= push.data;
        acc_cnt    <= acc_cnt + 3'd1;
        acc_last   <= push.last;
        acc_reboot <= push.reboot;
      end
    end
  end

endmodule

// ===== hw/rtl/modbus_rtu_slave_frame_handler_core.sv =====
// Modbus RTU slave frame handler: frame capture, checks, function 03/16 and response.
//
// rx channel: one frame byte per word (rx_byte, frame_end marks the final byte).
// tx channel: response words of up to four bytes, first byte in tx_bytes[7:0];
// tx_last marks the word with the high CRC byte, reboot_request is set on that
// word after a one-word write to register 0xFF00.
// cfg port: cfg_we/cfg_index/cfg_data write slave_address (0) or store base (1).
// For each received byte the CRC-16 unit shifts one bit per cycle
// and the byte after it is taken once the shift is done.
// After the end-marked byte: the checks in ST_CHK1 and ST_CHK2, the stored words of a
// function 16 write (ST_WR_RD0, ST_WR_RD1, ST_WR_WR per word), then each response
// byte through the same CRC unit and finally the two CRC bytes.
// Frames that fail address, CRC or length give no words.
// Reset zeroes the register store in a sweep over all STORE_WORDS words; rx_stall
// stays high during it. Configuration writes are taken at any time.
// A stalled tx word holds; one more word is assembled behind it, then the
// response sequencer waits, and rx_stall stays high until the reply is queued.
module modbus_rtu_slave_frame_handler_core
  import mbs_pkg::*;
#(
  parameter int FRAME_BYTES   = 256,
  parameter int STORE_WORDS   = 256,
  parameter int MAX_READ_REGS = 125
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  rx_word_t    rx_word,
  output logic        tx_valid,
  input  logic        tx_stall,
  output tx_word_t    tx_word,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int LW = $clog2(FRAME_BYTES + 1);
  localparam int FW = $clog2(FRAME_BYTES);
  localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

  state_t      state, state_next;

  logic [7:0]  slave_address;
  logic [15:0] store_base;

  logic [LW-1:0] len;
  logic          ovf;
  logic          end_q;
  logic [7:0]    hdr [HDR_BYTES];
  logic [7:0]    prev1, prev2;

  logic          frame_ok, ge_q, rd_bad, wr_bad;
  logic [15:0]   off_q;
  resp_kind_t    kind;
  logic [7:0]    err_code;
  logic          reboot_q;
  logic [7:0]    nbody;
  logic [7:0]    k;
  logic [AW-1:0] wptr;
  logic [6:0]    wcnt;
  logic [FW-1:0] p;
  logic [7:0]    wr_hi;

  logic [7:0]    fb_mem [FRAME_BYTES];
  logic [7:0]    fb_q;
  logic          fb_re;
  logic [FW-1:0] fb_raddr;

  logic          accept, in_room;
  crc_cmd_t      crc_cmd;
  logic [15:0]   crc_val;
  logic          crc_busy;
  pk_push_t      pk_push;
  logic          pk_ready;
  logic          st_we, st_re, st_busy;
  logic [15:0]   st_rdata;

  logic [15:0]   cnt16, reg16;
  logic          is_rd, is_wr, in_store, is_ff00, wr_store;
  resp_kind_t    dec_kind;
  logic [7:0]    dec_err;
  logic          dec_reboot;
  logic [7:0]    dec_nbody;
  logic [7:0]    body_byte;

  mbs_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .cmd  (crc_cmd),
    .crc  (crc_val),
    .busy (crc_busy)
  );

  mbs_store #(
    .STORE_WORDS (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .we    (st_we),
    .waddr (wptr),
    .wdata ({wr_hi, fb_q}),
    .re    (st_re),
    .raddr (wptr),
    .rdata (st_rdata),
    .busy  (st_busy)
  );

  mbs_txpack u_pack (
    .clk      (clk),
    .rst      (rst),
    .push     (pk_push),
    .ready    (pk_ready),
    .tx_valid (tx_valid),
    .tx_stall (tx_stall),
    .tx_word  (tx_word)
  );

  // frame decode
  assign cnt16 = {hdr[4], hdr[5]};
  assign reg16 = {hdr[2], hdr[3]};
  assign is_rd = (hdr[1] == FN_READ_HOLDING);
  assign is_wr = (hdr[1] == FN_WRITE_MULTI);
  assign in_store = ge_q && (({2'b00, off_q} + {2'b00, cnt16}) <= 18'(STORE_WORDS));
  assign is_ff00 = (reg16 == REBOOT_REG) && (cnt16 == 16'd1);
  assign wr_store = is_wr && !wr_bad && in_store;
  assign in_room = !ovf && (len < LW'(FRAME_BYTES));

  always_comb begin
    dec_kind   = RK_EXC;
    dec_err    = EXC_ILLEGAL_FUNCTION;
    dec_reboot = 1'b0;
    if (is_rd) begin
      if (rd_bad) begin
        dec_err = EXC_ILLEGAL_VALUE;
      end else if (in_store) begin
        dec_kind = RK_READ;
      end else if (is_ff00) begin
        dec_kind = RK_READ_ZERO;
      end else begin
        dec_err = EXC_ILLEGAL_ADDRESS;
      end
    end else if (is_wr) begin
      if (wr_bad) begin
        dec_err = EXC_ILLEGAL_VALUE;
      end else if (in_store) begin
        dec_kind = RK_WRITE;
      end else if (is_ff00) begin
        dec_kind   = RK_WRITE;
        dec_reboot = 1'b1;
      end else begin
        dec_err = EXC_ILLEGAL_ADDRESS;
      end
    end
    unique case (dec_kind)
      RK_EXC:       dec_nbody = 8'd3;
      RK_READ:      dec_nbody = {hdr[5][6:0], 1'b0} + 8'd3;
      RK_READ_ZERO: dec_nbody = 8'd5;
      RK_WRITE:     dec_nbody = 8'd6;
      default:      dec_nbody = 8'd3;
    endcase
  end

  always_comb begin
    case (k)
      8'd0: body_byte = hdr[0];
      8'd1: body_byte = (kind == RK_EXC) ? (hdr[1] | EXC_FLAG) : hdr[1];
      8'd2: begin
        case (kind)
          RK_EXC:       body_byte = err_code;
          RK_READ:      body_byte = {hdr[5][6:0], 1'b0};
          RK_READ_ZERO: body_byte = 8'd2;
          default:      body_byte = hdr[2];
        endcase
      end
      default: begin
        case (kind)
          RK_READ:  body_byte = k[0] ? st_rdata[15:8] : st_rdata[7:0];
          RK_WRITE: begin
            case (k)
              8'd3:    body_byte = hdr[3];
              8'd4:    body_byte = hdr[4];
              default: body_byte = hdr[5];
            endcase
          end
          default:  body_byte = 8'h00;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    accept      = 1'b0;
    rx_stall    = 1'b1;
    crc_cmd     = '0;
    pk_push     = '0;
    st_we       = 1'b0;
    st_re       = 1'b0;
    fb_re       = 1'b0;
    fb_raddr    = p;
    unique case (state)
      ST_IDLE: begin
        rx_stall = st_busy;
        accept   = rx_valid && !st_busy;
        if (accept) begin
          crc_cmd.start = in_room && (len >= LW'(2));
          crc_cmd.din   = prev2;
          state_next    = ST_RXWAIT;
        end
      end
      ST_RXWAIT: begin
        if (!crc_busy) begin
          state_next = end_q ? ST_CHK1 : ST_IDLE;
        end
      end
      ST_CHK1: state_next = ST_CHK2;
      ST_CHK2: begin
        crc_cmd.clr = 1'b1;
        if (!frame_ok) begin
          state_next = ST_IDLE;
        end else if (wr_store) begin
          state_next = ST_WR_RD0;
        end else begin
          state_next = ST_TX_BYTE;
        end
      end
      ST_WR_RD0: begin
        fb_re      = 1'b1;
        state_next = ST_WR_RD1;
      end
      ST_WR_RD1: begin
        fb_re      = 1'b1;
        fb_raddr   = p + FW'(1);
        state_next = ST_WR_WR;
      end
      ST_WR_WR: begin
        st_we      = 1'b1;
        state_next = (wcnt == 7'd1) ? ST_TX_BYTE : ST_WR_RD0;
      end
      ST_TX_BYTE: begin
        if (pk_ready) begin
          pk_push.valid = 1'b1;
          pk_push.data  = body_byte;
          crc_cmd.start = 1'b1;
          crc_cmd.din   = body_byte;
          st_re         = (kind == RK_READ) && !k[0] && (k >= 8'd2) &&
                          ((k + 8'd1) < nbody);
          state_next    = ST_TX_CRC;
        end
      end
      ST_TX_CRC: begin
        if (!crc_busy) begin
          state_next = (k == nbody) ? ST_TX_LO : ST_TX_BYTE;
        end
      end
      ST_TX_LO: begin
        if (pk_ready) begin
          pk_push.valid = 1'b1;
          pk_push.data  = crc_val[7:0];
          state_next    = ST_TX_HI;
        end
      end
      ST_TX_HI: begin
        if (pk_ready) begin
          pk_push.valid  = 1'b1;
          pk_push.data   = crc_val[15:8];
          pk_push.last   = 1'b1;
          pk_push.reboot = reboot_q;
          crc_cmd.clr    = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // receive side and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_ADDRESS_RESET;
      store_base    <= STORE_BASE_RESET;
      len           <= '0;
      ovf           <= 1'b0;
      end_q         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SLAVE_ADDRESS: slave_address <= cfg_data[7:0];
          CFG_STORE_BASE:    store_base    <= cfg_data;
          default:           store_base    <= cfg_data;
        endcase
      end
      if (accept) begin
        end_q <= rx_word.frame_end;
        if (in_room) begin
          if (len < LW'(HDR_BYTES)) begin
            hdr[len[2:0]] <= rx_word.rx_byte;
          end
          prev2 <= prev1;
          prev1 <= rx_word.rx_byte;
          len   <= len + LW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (state == ST_CHK2) begin
        len <= '0;
        ovf <= 1'b0;
      end
    end
  end

  // frame buffer
  always_ff @(posedge clk) begin
    if (accept && in_room) begin
      fb_mem[len[FW-1:0]] <= rx_word.rx_byte;
    end
    if (fb_re) begin
      fb_q <= fb_mem[fb_raddr];
    end
  end

  // check and response datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_CHK1: begin
        frame_ok <= !ovf && (len >= LW'(4)) && (hdr[0] == slave_address) &&
                    (crc_val == {prev1, prev2});
        ge_q     <= (reg16 >= store_base);
        off_q    <= reg16 - store_base;
        rd_bad   <= (len != LW'(8)) || (cnt16 == 16'd0) ||
                    (cnt16 > 16'(MAX_READ_REGS));
        wr_bad   <= (len < LW'(9)) || (cnt16 == 16'd0) || (cnt16 > WRITE_REGS_LIMIT) ||
                    (hdr[6] != {hdr[5][6:0], 1'b0}) ||
                    (18'(len) != ({1'b0, cnt16, 1'b0} + 18'd9));
      end
      ST_CHK2: begin
        kind     <= dec_kind;
        err_code <= dec_err;
        reboot_q <= dec_reboot;
        nbody    <= dec_nbody;
        k        <= 8'd0;
        p        <= FW'(7);
        wptr     <= off_q[AW-1:0];
        wcnt     <= hdr[5][6:0];
      end
      ST_WR_RD1: wr_hi <= fb_q;
      ST_WR_WR: begin
        wptr <= wptr + AW'(1);
        p    <= p + FW'(2);
        wcnt <= wcnt - 7'd1;
      end
      ST_TX_BYTE: begin
        if (pk_push.valid) begin
          k <= k + 8'd1;
        end
        if (st_re) begin
          wptr <= wptr + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_crc_start_idle: assert property (@(posedge clk) disable iff (rst)
    crc_cmd.start |-> !crc_busy)
    else $error("CRC start while unit busy");

  a_push_ready: assert property (@(posedge clk) disable iff (rst)
    pk_push.valid |-> pk_ready)
    else $error("byte pushed into full packer");

  a_store_write_after_clear: assert property (@(posedge clk) disable iff (rst)
    st_we |-> !st_busy)
    else $error("store write during clear sweep");

  a_no_rx_during_response: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TX_BYTE || state == ST_TX_CRC) |-> rx_stall)
    else $error("rx taken while response in progress");
`endif

endmodule
